// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level mixer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define LF_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Checks that a consequence holds in the same cycle as its cause.
`define LF_ASSERT_IMPL(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
    else $error("assertion failed");

`endif

// ===== design/lf_pkg.sv =====
`default_nettype none

package lf_pkg;

  localparam int SpeedW = 12;
  localparam int WheelW = 13;
  localparam int PatW   = 4;

  typedef enum logic [2:0] {
    REG_FWD_QUICK    = 3'd0,
    REG_FWD_GENTLE   = 3'd1,
    REG_STRAFE_TRIM  = 3'd2,
    REG_STRAFE_HARD  = 3'd3,
    REG_YAW_TRIM     = 3'd4,
    REG_YAW_HARD     = 3'd5,
    REG_SEARCH_SPEED = 3'd6,
    REG_SPEED_LIMIT  = 3'd7
  } cfg_reg_t;

  localparam logic [SpeedW-1:0] ResetFwdQuick    = 12'd1200;
  localparam logic [SpeedW-1:0] ResetFwdGentle   = 12'd800;
  localparam logic [SpeedW-1:0] ResetStrafeTrim  = 12'd350;
  localparam logic [SpeedW-1:0] ResetStrafeHard  = 12'd650;
  localparam logic [SpeedW-1:0] ResetYawTrim     = 12'd250;
  localparam logic [SpeedW-1:0] ResetYawHard     = 12'd500;
  localparam logic [SpeedW-1:0] ResetSearchSpeed = 12'd500;
  localparam logic [SpeedW-1:0] ResetSpeedLimit  = 12'd3000;

  typedef struct packed {
    logic [SpeedW-1:0] fwd_quick;
    logic [SpeedW-1:0] fwd_gentle;
    logic [SpeedW-1:0] strafe_trim;
    logic [SpeedW-1:0] strafe_hard;
    logic [SpeedW-1:0] yaw_trim;
    logic [SpeedW-1:0] yaw_hard;
    logic [SpeedW-1:0] search_speed;
    logic [SpeedW-1:0] speed_limit;
  } cfg_t;

  // Body speeds of one item as handed from the front to the back.
  typedef struct packed {
    logic [SpeedW-1:0]        vx;
    logic signed [WheelW-1:0] vy;
    logic signed [WheelW-1:0] wz;
    logic                     junction;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/line_follow_mecanum_mixer.sv =====
// Channel     Handshake                 Payload
// input       push / full               line_pattern [3:0]
// result      empty / pop               wheel_* [12:0] signed, junction_found
// config      cfg_valid / cfg_ready     cfg_index [2:0], cfg_data [11:0]
//
// An item is classified in the cycle it is accepted and waits in a two-entry queue.
// The mixer steps through idle, mix, max, one step per wheel and done; when a wheel exceeds
// the speed limit, each of the four wheels is scaled by a multiply and a pass of the shared
// restoring divider. It takes the next item only after the last has reached the output.
// Reset is synchronous; it restores the register defaults and forgets the line side.
// A stalled result holds the mixer, while the front keeps accepting until the queue fills.
`default_nettype none
`include "assert_macros.svh"

module line_follow_mecanum_mixer import lf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [PatW-1:0]          line_pattern,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [WheelW-1:0] wheel_front_left,
  output logic signed [WheelW-1:0] wheel_front_right,
  output logic signed [WheelW-1:0] wheel_back_left,
  output logic signed [WheelW-1:0] wheel_back_right,
  output logic                     junction_found,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [SpeedW-1:0]        cfg_data
);

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t q_item;
  logic q_empty;
  logic q_pop;
  logic accept;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fwd_quick    <= ResetFwdQuick;
      cfg.fwd_gentle   <= ResetFwdGentle;
      cfg.strafe_trim  <= ResetStrafeTrim;
      cfg.strafe_hard  <= ResetStrafeHard;
      cfg.yaw_trim     <= ResetYawTrim;
      cfg.yaw_hard     <= ResetYawHard;
      cfg.search_speed <= ResetSearchSpeed;
      cfg.speed_limit  <= ResetSpeedLimit;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FWD_QUICK:    cfg.fwd_quick    <= cfg_data;
        REG_FWD_GENTLE:   cfg.fwd_gentle   <= cfg_data;
        REG_STRAFE_TRIM:  cfg.strafe_trim  <= cfg_data;
        REG_STRAFE_HARD:  cfg.strafe_hard  <= cfg_data;
        REG_YAW_TRIM:     cfg.yaw_trim     <= cfg_data;
        REG_YAW_HARD:     cfg.yaw_hard     <= cfg_data;
        REG_SEARCH_SPEED: cfg.search_speed <= cfg_data;
        REG_SPEED_LIMIT:  cfg.speed_limit  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .pattern (line_pattern),
    .cfg     (cfg),
    .cmd     (front_cmd)
  );

  lf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (front_cmd),
    .full    (full),
    .pop     (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  lf_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_item            (q_item),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .speed_limit       (cfg.speed_limit),
    .empty             (empty),
    .pop               (pop),
    .wheel_front_left  (wheel_front_left),
    .wheel_front_right (wheel_front_right),
    .wheel_back_left   (wheel_back_left),
    .wheel_back_right  (wheel_back_right),
    .junction_found    (junction_found)
  );

  logic signed [WheelW-1:0] lim_pos;
  assign lim_pos = $signed({1'b0, cfg.speed_limit});

  `LF_ASSERT_IMPL(a_junction_stops, !empty && junction_found,
    wheel_front_left == '0 && wheel_front_right == '0 &&
    wheel_back_left == '0 && wheel_back_right == '0)
  `LF_ASSERT_IMPL(a_front_left_limit, !empty,
    wheel_front_left <= lim_pos && wheel_front_left >= -lim_pos)
  `LF_ASSERT_IMPL(a_back_right_limit, !empty,
    wheel_back_right <= lim_pos && wheel_back_right >= -lim_pos)

endmodule

`default_nettype wire

// ===== design/lf_front.sv =====
`default_nettype none

module lf_front import lf_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [PatW-1:0] pattern,
  input  cfg_t            cfg,
  output cmd_t            cmd
);

  typedef enum logic [1:0] {
    DIR_UNKNOWN = 2'd0,
    DIR_LEFT    = 2'd1,
    DIR_RIGHT   = 2'd2,
    DIR_SPARE   = 2'd3
  } dir_t;

  localparam logic [PatW-1:0] PatCenter    = 4'h6;
  localparam logic [PatW-1:0] PatLeftIn    = 4'h2;
  localparam logic [PatW-1:0] PatLeftFar   = 4'h1;
  localparam logic [PatW-1:0] PatLeftPair  = 4'h3;
  localparam logic [PatW-1:0] PatRightIn   = 4'h4;
  localparam logic [PatW-1:0] PatRightFar  = 4'h8;
  localparam logic [PatW-1:0] PatRightPair = 4'hC;
  localparam logic [PatW-1:0] PatLeftWide  = 4'h7;
  localparam logic [PatW-1:0] PatRightWide = 4'hE;
  localparam logic [PatW-1:0] PatJunction  = 4'hF;
  localparam logic [PatW-1:0] PatLost      = 4'h0;

  dir_t last_direction;
  dir_t last_direction_next;

  logic signed [WheelW-1:0] ss_pos, sb_pos, ts_pos, tb_pos;

  assign ss_pos = $signed({1'b0, cfg.strafe_trim});
  assign sb_pos = $signed({1'b0, cfg.strafe_hard});
  assign ts_pos = $signed({1'b0, cfg.yaw_trim});
  assign tb_pos = $signed({1'b0, cfg.yaw_hard});

  always_comb begin
    cmd                 = '0;
    cmd.vx              = cfg.fwd_gentle;
    last_direction_next = last_direction;
    unique case (pattern)
      PatCenter: begin
        cmd.vx              = cfg.fwd_quick;
        last_direction_next = DIR_UNKNOWN;
      end
      PatLeftIn: begin
        cmd.vx              = cfg.fwd_quick;
        cmd.vy              = -ss_pos;
        cmd.wz              = -ts_pos;
        last_direction_next = DIR_LEFT;
      end
      PatLeftFar, PatLeftPair: begin
        cmd.vy              = -sb_pos;
        cmd.wz              = -tb_pos;
        last_direction_next = DIR_LEFT;
      end
      PatRightIn: begin
        cmd.vx              = cfg.fwd_quick;
        cmd.vy              = ss_pos;
        cmd.wz              = ts_pos;
        last_direction_next = DIR_RIGHT;
      end
      PatRightFar, PatRightPair: begin
        cmd.vy              = sb_pos;
        cmd.wz              = tb_pos;
        last_direction_next = DIR_RIGHT;
      end
      PatLeftWide: begin
        cmd.vy              = -ss_pos;
        cmd.wz              = -ts_pos;
        last_direction_next = DIR_LEFT;
      end
      PatRightWide: begin
        cmd.vy              = ss_pos;
        cmd.wz              = ts_pos;
        last_direction_next = DIR_RIGHT;
      end
      PatJunction: begin
        cmd.vx       = '0;
        cmd.junction = 1'b1;
      end
      PatLost: begin
        cmd.vx = cfg.search_speed;
        if (last_direction == DIR_LEFT) begin
          cmd.vy = -sb_pos;
          cmd.wz = -tb_pos;
        end else if (last_direction == DIR_RIGHT) begin
          cmd.vy = sb_pos;
          cmd.wz = tb_pos;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_direction <= DIR_UNKNOWN;
    end else if (accept) begin
      last_direction <= last_direction_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/lf_queue.sv =====
`default_nettype none

module lf_queue import lf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_item,
  output logic full,
  input  logic pop,
  output cmd_t rd_item,
  output logic empty
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign rd_item = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// ===== design/lf_back.sv =====
`default_nettype none

module lf_back import lf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     q_item,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  logic [SpeedW-1:0]        speed_limit,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [WheelW-1:0] wheel_front_left,
  output logic signed [WheelW-1:0] wheel_front_right,
  output logic signed [WheelW-1:0] wheel_back_left,
  output logic signed [WheelW-1:0] wheel_back_right,
  output logic                     junction_found
);

  localparam int SumW  = WheelW + 2;
  localparam int MagW  = SumW - 1;
  localparam int ProdW = MagW + SpeedW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIX,
    S_MAX,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;

  cmd_t                     item;
  logic                     wsign [4];
  logic [MagW-1:0]          wmag  [4];
  logic signed [WheelW-1:0] res   [4];
  logic [MagW-1:0]          max_mag;
  logic                     need_scale;
  logic [1:0]               idx;
  logic [ProdW-1:0]         prod;
  logic [MagW-1:0]          rem;
  logic [SpeedW-1:0]        quo;
  logic [3:0]               cnt;
  logic                     out_valid;

  logic signed [SumW-1:0] vx_s, vy_s, wz_s;
  logic signed [SumW-1:0] wsum [4];
  logic [MagW-1:0]        m01, m23, m_all;
  logic [MagW-1:0]        rem_src;
  logic [MagW:0]          trial;
  logic                   trial_ok;
  logic [SpeedW-1:0]      quo_next;
  logic [SpeedW-1:0]      mag_final;
  logic [SpeedW-1:0]      mag_plain;
  logic                   load_out;

  assign vx_s = $signed({3'b000, item.vx});
  assign vy_s = SumW'(item.vy);
  assign wz_s = SumW'(item.wz);

  assign wsum[0] = vx_s - vy_s - wz_s;
  assign wsum[1] = vx_s + vy_s + wz_s;
  assign wsum[2] = vx_s + vy_s - wz_s;
  assign wsum[3] = vx_s - vy_s + wz_s;

  assign m01   = (wmag[0] > wmag[1]) ? wmag[0] : wmag[1];
  assign m23   = (wmag[2] > wmag[3]) ? wmag[2] : wmag[3];
  assign m_all = (m01 > m23) ? m01 : m23;

  // The first step starts from the upper product bits, which stay below the divisor.
  assign rem_src  = (cnt == 4'd0) ? prod[ProdW-1:SpeedW] : rem;
  assign trial    = {rem_src, prod[SpeedW-1]};
  assign trial_ok = trial >= {1'b0, max_mag};
  assign quo_next = {quo[SpeedW-2:0], trial_ok};

  assign mag_plain = (wmag[idx] > MagW'(speed_limit)) ? speed_limit : wmag[idx][SpeedW-1:0];
  assign mag_final = (quo_next > speed_limit) ? speed_limit : quo_next;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign empty    = !out_valid;
  assign load_out = (state == S_DONE) && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            item  <= q_item;
            state <= S_MIX;
          end
        end
        S_MIX: begin
          for (int i = 0; i < 4; i++) begin
            wsign[i] <= wsum[i][SumW-1];
            wmag[i]  <= wsum[i][SumW-1] ? MagW'(-wsum[i]) : wsum[i][MagW-1:0];
          end
          state <= S_MAX;
        end
        S_MAX: begin
          max_mag    <= m_all;
          need_scale <= m_all > MagW'(speed_limit);
          idx        <= 2'd0;
          state      <= S_MUL;
        end
        S_MUL: begin
          if (need_scale) begin
            prod  <= ProdW'(wmag[idx]) * ProdW'(speed_limit);
            cnt   <= 4'd0;
            state <= S_DIV;
          end else begin
            res[idx] <= wsign[idx] ? -$signed({1'b0, mag_plain})
                                   : $signed({1'b0, mag_plain});
            idx      <= idx + 2'd1;
            state    <= (idx == 2'd3) ? S_DONE : S_MUL;
          end
        end
        S_DIV: begin
          rem  <= trial_ok ? MagW'(trial - {1'b0, max_mag}) : trial[MagW-1:0];
          prod <= {prod[ProdW-2:0], 1'b0};
          quo  <= quo_next;
          cnt  <= cnt + 4'd1;
          if (cnt == 4'(SpeedW - 1)) begin
            res[idx] <= wsign[idx] ? -$signed({1'b0, mag_final})
                                   : $signed({1'b0, mag_final});
            idx      <= idx + 2'd1;
            state    <= (idx == 2'd3) ? S_DONE : S_MUL;
          end
        end
        S_DONE: begin
          if (load_out) begin
            wheel_front_left  <= res[0];
            wheel_front_right <= res[1];
            wheel_back_left   <= res[2];
            wheel_back_right  <= res[3];
            junction_found    <= item.junction;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
